// File: hw/rtl/q2r_pkg.sv
// Package for the quaternion to rotation matrix block.
// Widths, derived constants and payload types. No dependencies.
package q2r_pkg;

  localparam int unsigned InWidth     = 16;
  localparam int unsigned OutFracBits = 14;
  localparam int unsigned OutWidth    = OutFracBits + 2;

  typedef struct packed {
    logic signed [InWidth-1:0] q_w;
    logic signed [InWidth-1:0] q_x;
    logic signed [InWidth-1:0] q_y;
    logic signed [InWidth-1:0] q_z;
  } quat_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] m00;
    logic signed [OutWidth-1:0] m01;
    logic signed [OutWidth-1:0] m02;
    logic signed [OutWidth-1:0] m10;
    logic signed [OutWidth-1:0] m11;
    logic signed [OutWidth-1:0] m12;
    logic signed [OutWidth-1:0] m20;
    logic signed [OutWidth-1:0] m21;
    logic signed [OutWidth-1:0] m22;
  } mat_t;

endpackage

// File: hw/rtl/q2r_if.sv
// Valid/ready stream interfaces for quaternion in and matrix out.
// Depends on q2r_pkg.
interface q2r_quat_if;
  logic          valid;
  logic          ready;
  q2r_pkg::quat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface q2r_mat_if;
  logic          valid;
  logic          ready;
  q2r_pkg::mat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/q2r_div.sv
// Pipelined restoring divider: round(num/den * 2^FracBits), halves away from zero.
// One quotient bit per stage; depends on nothing but its parameters.
module q2r_div #(
  parameter int unsigned NumWidth = 34,
  parameter int unsigned FracBits = 14,
  parameter int unsigned OutWidth = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [NumWidth-1:0] num_i,
  input  logic        [NumWidth-1:0] den_i,
  output logic signed [OutWidth-1:0] res_o
);
  // num magnitude <= den, den < 2^(NumWidth-1); remainder stays below 2*den
  localparam int unsigned Steps = FracBits + 2;
  localparam int unsigned QW    = FracBits + 2;

  logic [NumWidth-1:0] r_q   [Steps+1];
  logic [NumWidth-1:0] den_q [Steps+1];
  logic [QW-1:0]       qt_q  [Steps+1];
  logic                neg_q [Steps+1];
  logic [QW-1:0]       rnd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= num_i[NumWidth-1];
      r_q[0]   <= num_i[NumWidth-1] ? NumWidth'(-num_i) : NumWidth'(num_i);
      den_q[0] <= den_i;
      qt_q[0]  <= '0;
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [NumWidth-1:0] rs;
    logic                ge;
    always_comb begin
      rs = (s == 0) ? r_q[s] : {r_q[s][NumWidth-2:0], 1'b0};
      ge = rs >= den_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]   <= ge ? rs - den_q[s] : rs;
        den_q[s+1] <= den_q[s];
        qt_q[s+1]  <= {qt_q[s][QW-2:0], ge};
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign rnd   = QW'((qt_q[Steps] + QW'(1)) >> 1);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= neg_q[Steps] ? OutWidth'(-$signed({1'b0, rnd})) : OutWidth'($signed({1'b0, rnd}));
    end
  end
endmodule

// File: hw/rtl/quaternion_to_rotation_matrix.sv
// Channel  | dir | payload
// in_if    | in  | q_w q_x q_y q_z, signed IN_WIDTH
// out_if   | out | m00..m22, signed Q1.OUT_FRAC_BITS
// One transaction per cycle while out_if is not stalled. Pipeline: 3 product/sum stages + OUT_FRAC_BITS+4
// divider stages, the divider resolving one quotient bit per stage.
// The pipeline advances as a whole: a stall at the output freezes every stage.
// Reset clears the valid bits only.
module quaternion_to_rotation_matrix #(
  parameter int unsigned IN_WIDTH      = q2r_pkg::InWidth,
  parameter int unsigned OUT_FRAC_BITS = q2r_pkg::OutFracBits
) (
  input logic clk_i,
  input logic rst_ni,
  q2r_quat_if.sink  in_if,
  q2r_mat_if.source out_if
);
  import q2r_pkg::*;

  localparam int unsigned PW    = 2 * IN_WIDTH + 1;
  localparam int unsigned NW    = 2 * IN_WIDTH + 3;
  localparam int unsigned OW    = OUT_FRAC_BITS + 2;
  localparam int unsigned Lat   = 3 + OUT_FRAC_BITS + 4;

  logic              adv;
  logic [Lat-1:0]    vld_q;

  assign adv         = !vld_q[Lat-1] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_if.valid};
    end
  end

  // stage 1: register inputs
  logic signed [IN_WIDTH-1:0] w_q, x_q, y_q, z_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q <= IN_WIDTH'(in_if.data.q_w);
      x_q <= IN_WIDTH'(in_if.data.q_x);
      y_q <= IN_WIDTH'(in_if.data.q_y);
      z_q <= IN_WIDTH'(in_if.data.q_z);
    end
  end

  // stage 2: ten products
  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, zw_q, yw_q, zx_q, yz_q, xw_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ww_q <= PW'(w_q * w_q); xx_q <= PW'(x_q * x_q);
      yy_q <= PW'(y_q * y_q); zz_q <= PW'(z_q * z_q);
      xy_q <= PW'(x_q * y_q); zw_q <= PW'(z_q * w_q);
      yw_q <= PW'(y_q * w_q); zx_q <= PW'(z_q * x_q);
      yz_q <= PW'(y_q * z_q); xw_q <= PW'(x_q * w_q);
    end
  end

  // stage 3: numerators and norm
  logic signed [NW-1:0] num_q [9];
  logic        [NW-1:0] n_q;
  logic                 zero_q;
  logic signed [NW-1:0] a, b, c, d;
  logic        [NW-1:0] n_d;
  assign a   = NW'(ww_q); assign b = NW'(xx_q);
  assign c   = NW'(yy_q); assign d = NW'(zz_q);
  assign n_d = NW'(a + b + c + d);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q[0] <= a + b - c - d;
      num_q[1] <= (NW'(xy_q) - NW'(zw_q)) <<< 1;
      num_q[2] <= (NW'(yw_q) + NW'(zx_q)) <<< 1;
      num_q[3] <= (NW'(xy_q) + NW'(zw_q)) <<< 1;
      num_q[4] <= a + c - b - d;
      num_q[5] <= (NW'(yz_q) - NW'(xw_q)) <<< 1;
      num_q[6] <= (NW'(zx_q) - NW'(yw_q)) <<< 1;
      num_q[7] <= (NW'(yz_q) + NW'(xw_q)) <<< 1;
      num_q[8] <= a + d - b - c;
      zero_q   <= (n_d == '0);
      // zero norm: divide 1 by 1 on diagonal, 0 elsewhere
      n_q      <= (n_d == '0) ? NW'(1) : n_d;
    end
  end

  logic signed [NW-1:0] dnum [9];
  logic signed [OW-1:0] res  [9];
  for (genvar k = 0; k < 9; k++) begin : g_div
    assign dnum[k] = zero_q ? ((k % 4 == 0) ? NW'(1) : '0) : num_q[k];
    q2r_div #(.NumWidth(NW), .FracBits(OUT_FRAC_BITS), .OutWidth(OW)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (dnum[k]),
      .den_i (n_q),
      .res_o (res[k])
    );
  end

  assign out_if.valid    = vld_q[Lat-1];
  assign out_if.data.m00 = res[0];
  assign out_if.data.m01 = res[1];
  assign out_if.data.m02 = res[2];
  assign out_if.data.m10 = res[3];
  assign out_if.data.m11 = res[4];
  assign out_if.data.m12 = res[5];
  assign out_if.data.m20 = res[6];
  assign out_if.data.m21 = res[7];
  assign out_if.data.m22 = res[8];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready == (!out_if.valid || out_if.ready))
    else $error("input ready not tied to output drain");
  a_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (res[0] <= OW'(1 << OUT_FRAC_BITS)))
    else $error("diagonal entry out of range");
endmodule

// File: test/tb_top.sv
// Testbench for quaternion_to_rotation_matrix: streams quaternions and checks
// every matrix against an in-bench exact rational predictor.
// Depends on q2r_pkg, q2r_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import q2r_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  q2r_quat_if quat_bus ();
  q2r_mat_if  mat_bus ();

  quaternion_to_rotation_matrix dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (quat_bus.sink),
    .out_if(mat_bus.source)
  );

  mat_t  pending_mats[$];
  int    n_errors = 0;
  bit    idle_enable = 1'b1;
  bit    hold_off = 1'b0;
  int    stall_left = 0;

  initial begin
    quat_bus.valid = 1'b0;
    quat_bus.data  = '0;
    mat_bus.ready  = 1'b0;
  end

  // round(num * 2^frac / den), halves away from zero; den > 0
  function automatic logic signed [OutWidth-1:0] scaled_ratio(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< (OutFracBits + 1)) / den + 1) >>> 1;
    return OutWidth'((num < 0) ? -q : q);
  endfunction

  function automatic mat_t rotation_of(quat_t q);
    longint w, x, y, z, n;
    mat_t m;
    w = q.q_w; x = q.q_x; y = q.q_y; z = q.q_z;
    n = w*w + x*x + y*y + z*z;
    if (n == 0) begin
      m = '0;
      m.m00 = OutWidth'(1 << OutFracBits);
      m.m11 = OutWidth'(1 << OutFracBits);
      m.m22 = OutWidth'(1 << OutFracBits);
      return m;
    end
    m.m00 = scaled_ratio(w*w + x*x - y*y - z*z, n);
    m.m01 = scaled_ratio(2*(x*y - z*w), n);
    m.m02 = scaled_ratio(2*(y*w + z*x), n);
    m.m10 = scaled_ratio(2*(x*y + w*z), n);
    m.m11 = scaled_ratio(w*w + y*y - x*x - z*z, n);
    m.m12 = scaled_ratio(2*(z*y - x*w), n);
    m.m20 = scaled_ratio(2*(x*z - y*w), n);
    m.m21 = scaled_ratio(2*(y*z + w*x), n);
    m.m22 = scaled_ratio(w*w + z*z - x*x - y*y, n);
    return m;
  endfunction

  task automatic send_quat(quat_t q);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      quat_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    quat_bus.valid <= 1'b1;
    quat_bus.data  <= q;
    // ready is sampled at the edge itself, before any register updates
    @(posedge clk_i iff quat_bus.ready);
    pending_mats.push_back(rotation_of(q));
  endtask

  // output side: random stall bursts, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mat_bus.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_off) begin
      mat_bus.ready <= 1'b0;
    end else if (idle_enable && stall_left > 0) begin
      mat_bus.ready <= 1'b0;
      stall_left--;
    end else if (idle_enable && $urandom_range(0, 15) == 0) begin
      mat_bus.ready <= 1'b0;
      stall_left = $urandom_range(0, 14);
    end else begin
      mat_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    mat_t exp_m, got;
    if (rst_ni && mat_bus.valid && mat_bus.ready) begin
      got = mat_bus.data;
      if (pending_mats.size() == 0) begin
        $error("unexpected matrix %h", got);
        n_errors++;
      end else begin
        exp_m = pending_mats.pop_front();
        if (got.m00 !== exp_m.m00) begin $error("m00 exp %0d got %0d", exp_m.m00, got.m00); n_errors++; end
        if (got.m01 !== exp_m.m01) begin $error("m01 exp %0d got %0d", exp_m.m01, got.m01); n_errors++; end
        if (got.m02 !== exp_m.m02) begin $error("m02 exp %0d got %0d", exp_m.m02, got.m02); n_errors++; end
        if (got.m10 !== exp_m.m10) begin $error("m10 exp %0d got %0d", exp_m.m10, got.m10); n_errors++; end
        if (got.m11 !== exp_m.m11) begin $error("m11 exp %0d got %0d", exp_m.m11, got.m11); n_errors++; end
        if (got.m12 !== exp_m.m12) begin $error("m12 exp %0d got %0d", exp_m.m12, got.m12); n_errors++; end
        if (got.m20 !== exp_m.m20) begin $error("m20 exp %0d got %0d", exp_m.m20, got.m20); n_errors++; end
        if (got.m21 !== exp_m.m21) begin $error("m21 exp %0d got %0d", exp_m.m21, got.m21); n_errors++; end
        if (got.m22 !== exp_m.m22) begin $error("m22 exp %0d got %0d", exp_m.m22, got.m22); n_errors++; end
      end
    end
  end

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.q_w = InWidth'(w); q.q_x = InWidth'(x); q.q_y = InWidth'(y); q.q_z = InWidth'(z);
    return q;
  endfunction

  function automatic logic [InWidth-1:0] rand_field();
    case ($urandom_range(0, 3))
      0: return InWidth'(int'($urandom_range(0, 15)) - 8);
      1: return InWidth'(int'($urandom_range(0, 511)) - 256);
      default: return InWidth'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_quat(make_quat(0, 0, 0, 0));
    send_quat(make_quat(1, 0, 0, 0));
    send_quat(make_quat(0, 1, 0, 0));
    send_quat(make_quat(0, 0, 1, 0));
    send_quat(make_quat(0, 0, 0, 1));
    send_quat(make_quat(-32768, -32768, -32768, -32768));
    send_quat(make_quat(32767, 32767, 32767, 32767));
    send_quat(make_quat(-32768, 32767, -32768, 32767));
    send_quat(make_quat(-32768, 0, 0, 0));
    send_quat(make_quat(0, -32768, 0, 0));
    send_quat(make_quat(0, 0, 32767, 0));
    send_quat(make_quat(0, 0, 0, -32768));
    send_quat(make_quat(1, 1, 0, 0));
    send_quat(make_quat(1, 1, 1, 1));
    send_quat(make_quat(-1, 2, -3, 4));
    send_quat(make_quat(3, 0, 0, 1));
    send_quat(make_quat(-1, -1, -1, -1));
    send_quat(make_quat(32767, -1, 1, -32768));
  endtask

  task automatic test_random(int count);
    repeat (count)
      send_quat(make_quat($signed(rand_field()), $signed(rand_field()),
                          $signed(rand_field()), $signed(rand_field())));
  endtask

  // receiver holds off while the sender keeps offering, so the pipe backs up
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(60);
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic wait_drain();
    while (pending_mats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400);
    test_backpressure();
    test_random(400);
    idle_enable = 1'b0;
    test_random(150);
    quat_bus.valid <= 1'b0;
    wait_drain();
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
